[hdl/command_frame_classifier_assert.svh]
// Assertion macros for the command frame classifier.
// Included by the top level; the bodies are empty when SYNTH is defined.
`ifndef COMMAND_FRAME_CLASSIFIER_ASSERT_SVH
`define COMMAND_FRAME_CLASSIFIER_ASSERT_SVH

`ifndef SYNTH
// Checked on every rising edge outside reset.
`define CFC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("command_frame_classifier: assertion failed");
// Checked on every rising edge, reset included.
`define CFC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("command_frame_classifier: assertion failed");
`else
`define CFC_ASSERT(label, clk, rst, prop)
`define CFC_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

[hdl/cfc_pkg.sv]
// Shared types, header tables and CRC helper for the command frame classifier.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cfc_pkg;

  localparam int TAIL_BYTES = 7;
  localparam int HDR_COUNT  = 5;
  localparam int HDR_SLOTS  = 8;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_item_t;

  typedef enum logic [2:0] {
    CMD_TIME_SYNC = 3'd0,
    CMD_SET_RULES = 3'd1,
    CMD_READ_STATE = 3'd2,
    CMD_GET_RULES = 3'd3,
    CMD_RESTART   = 3'd4,
    CMD_NONE      = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED   = 3'd0,
    ST_TOO_SHORT  = 3'd1,
    ST_UNKNOWN    = 3'd2,
    ST_DEV_WRONG  = 3'd3,
    ST_CRC_WRONG  = 3'd4
  } status_t;

  typedef struct packed {
    cmd_t        command;
    status_t     status;
    logic [15:0] frame_length;
    logic [15:0] received_crc;
    logic [15:0] computed_crc;
  } verdict_item_t;

  // Frame state after the byte under work is taken in.
  typedef struct packed {
    logic [HDR_COUNT-1:0] hdr_match;
    logic [HDR_COUNT-1:0] dev_wrong;
    logic [15:0]          length;
    logic [15:0]          crc;
    logic [15:0]          rx_crc;
  } frame_view_t;

  // Headers in priority order, zero padded: $BDRMC $STR $READ $GETSTR $REST
  localparam logic [7:0] HDR_TEXT [HDR_COUNT][HDR_SLOTS] = '{
    '{8'h24, 8'h42, 8'h44, 8'h52, 8'h4D, 8'h43, 8'h00, 8'h00},
    '{8'h24, 8'h53, 8'h54, 8'h52, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h24, 8'h52, 8'h45, 8'h41, 8'h44, 8'h00, 8'h00, 8'h00},
    '{8'h24, 8'h47, 8'h45, 8'h54, 8'h53, 8'h54, 8'h52, 8'h00},
    '{8'h24, 8'h52, 8'h45, 8'h53, 8'h54, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] HDR_LEN [HDR_COUNT] = '{3'd6, 3'd4, 3'd5, 3'd7, 3'd5};
  localparam logic [HDR_COUNT-1:0] HDR_HAS_DEV = 5'b11110;
  localparam logic [HDR_COUNT-1:0] HDR_HAS_CRC = 5'b01110;

  // Modbus CRC16, one byte, LSB first.
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hdl/cfc_in_stage.sv]
// Input register of the command frame classifier.
// Depends on cfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfc_in_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               byte_valid,
  output logic                    byte_stall,
  input  wire cfc_pkg::byte_item_t byte_item,
  input  wire logic               advance,
  output logic                    held_valid,
  output cfc_pkg::byte_item_t     held_item
);
  import cfc_pkg::*;

  logic take;

  assign byte_stall = held_valid && !advance;
  assign take       = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_item <= byte_item;
    end
  end

endmodule

`default_nettype wire

[hdl/cfc_frame_state.sv]
// Per-frame state: header match flags, device byte check, CRC, tail line, count.
// Depends on cfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfc_frame_state (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                consume,
  input  wire cfc_pkg::byte_item_t byte_in,
  input  wire logic [7:0]          device_number,
  output cfc_pkg::frame_view_t     view,
  output logic [15:0]              count
);
  import cfc_pkg::*;

  logic [HDR_COUNT-1:0]             hdr_match, hdr_match_next;
  logic [HDR_COUNT-1:0]             dev_wrong, dev_wrong_next;
  logic [15:0]                      crc, crc_next;
  logic [TAIL_BYTES-1:0][7:0]       tail, tail_next;
  logic [15:0]                      count_next;
  logic [7:0]                       b;

  assign b = byte_in.data_byte;

  always_comb begin
    hdr_match_next = hdr_match;
    dev_wrong_next = dev_wrong;
    for (int i = 0; i < HDR_COUNT; i++) begin
      if (count < {13'd0, HDR_LEN[i]}) begin
        if (b != HDR_TEXT[i][count[2:0]]) begin
          hdr_match_next[i] = 1'b0;
        end
      end else if (count == {13'd0, HDR_LEN[i]} && HDR_HAS_DEV[i]) begin
        if (b != device_number) begin
          dev_wrong_next[i] = 1'b1;
        end
      end
    end
  end

  // CRC trails the input by the tail length.
  assign crc_next   = (count >= 16'(TAIL_BYTES)) ? crc16_byte(crc, tail[TAIL_BYTES-1]) : crc;
  assign tail_next  = {tail[TAIL_BYTES-2:0], b};
  assign count_next = (count == 16'hFFFF) ? count : count + 16'd1;

  always_comb begin
    view.hdr_match = hdr_match_next;
    view.dev_wrong = dev_wrong_next;
    view.length    = count_next;
    view.crc       = crc_next;
    view.rx_crc    = {tail_next[TAIL_BYTES-1], tail_next[TAIL_BYTES-2]};
  end

  always_ff @(posedge clk) begin
    if (rst || (consume && byte_in.last_byte)) begin
      hdr_match <= '1;
      dev_wrong <= '0;
      crc       <= CRC_INIT;
      tail      <= '0;
      count     <= '0;
    end else if (consume) begin
      hdr_match <= hdr_match_next;
      dev_wrong <= dev_wrong_next;
      crc       <= crc_next;
      tail      <= tail_next;
      count     <= count_next;
    end
  end

endmodule

`default_nettype wire

[hdl/cfc_verdict.sv]
// Frame classification and result register.
// Depends on cfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfc_verdict (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 advance,
  input  wire logic                 consume_last,
  input  wire cfc_pkg::frame_view_t view,
  output logic                      verdict_valid,
  output cfc_pkg::verdict_item_t    verdict_item
);
  import cfc_pkg::*;

  verdict_item_t result;

  always_comb begin
    result.command      = CMD_NONE;
    result.status       = ST_UNKNOWN;
    result.frame_length = view.length;
    result.received_crc = view.rx_crc;
    result.computed_crc = view.crc;
    if (view.length < 16'(TAIL_BYTES)) begin
      result.status       = ST_TOO_SHORT;
      result.received_crc = '0;
      result.computed_crc = '0;
    end else begin
      // Walk down so the first matching header in table order wins.
      for (int i = HDR_COUNT - 1; i >= 0; i--) begin
        if (view.hdr_match[i]) begin
          result.command = cmd_t'(3'(i));
          if (view.dev_wrong[i]) begin
            result.status = ST_DEV_WRONG;
          end else if (HDR_HAS_CRC[i] && view.rx_crc != view.crc) begin
            result.status = ST_CRC_WRONG;
          end else begin
            result.status = ST_ACCEPTED;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (advance) begin
      verdict_valid <= consume_last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && consume_last) begin
      verdict_item <= result;
    end
  end

endmodule

`default_nettype wire

[hdl/command_frame_classifier.sv]
// Command frame classifier: top level.
// Depends on cfc_pkg, cfc_in_stage, cfc_frame_state, cfc_verdict and the assert header.
//
// Usage:
//   Byte channel (byte_valid / byte_stall / byte_item): one frame byte per
//   transfer, last_byte set on the final byte of a frame.
//   Verdict channel (verdict_valid / verdict_stall / verdict_item): one
//   transfer per frame, carrying command, status, length and both CRC words.
//   cfg_write / cfg_data: writes the own device number (reset value 1);
//   write it only while no frame is in progress.
// Timing:
//   One byte per cycle sustained while the verdict channel does not stall. A
//   byte is first held in the input register, then the header, device and CRC
//   update plus classification happen in one pass into the result register,
//   from which the verdict is shown once the final byte has passed through.
// Reset (rst, synchronous): empties both registers, clears frame state,
//   device number back to 1.
// Stall: while a verdict is held, the pipeline freezes and byte_stall rises
//   once the input register is full; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none
`include "command_frame_classifier_assert.svh"

module command_frame_classifier (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 byte_valid,
  output logic                      byte_stall,
  input  wire cfc_pkg::byte_item_t  byte_item,
  output logic                      verdict_valid,
  input  wire logic                 verdict_stall,
  output cfc_pkg::verdict_item_t    verdict_item,
  input  wire logic                 cfg_write,
  input  wire logic [7:0]           cfg_data
);
  import cfc_pkg::*;

  logic        advance;
  logic        held_valid;
  byte_item_t  held_item;
  logic        consume;
  logic        consume_last;
  logic [7:0]  device_number;
  frame_view_t view;
  logic [15:0] count;

  assign advance      = !verdict_valid || !verdict_stall;
  assign consume      = held_valid && advance;
  assign consume_last = consume && held_item.last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_number <= 8'd1;
    end else if (cfg_write) begin
      device_number <= cfg_data;
    end
  end

  cfc_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  cfc_frame_state u_frame_state (
    .clk           (clk),
    .rst           (rst),
    .consume       (consume),
    .byte_in       (held_item),
    .device_number (device_number),
    .view          (view),
    .count         (count)
  );

  cfc_verdict u_verdict (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .consume_last  (consume_last),
    .view          (view),
    .verdict_valid (verdict_valid),
    .verdict_item  (verdict_item)
  );

  // Input only backs up when the held byte cannot move on.
  `CFC_ASSERT(a_stall_needs_held, clk, rst, byte_stall |-> (held_valid && verdict_valid))
  // Frame state starts over after the final byte.
  `CFC_ASSERT(a_count_cleared, clk, rst, consume_last |=> (count == 16'd0))
  // Short frames carry no command and no CRC words.
  `CFC_ASSERT(a_short_frame, clk, rst,
    (verdict_valid && verdict_item.status == ST_TOO_SHORT) |->
      (verdict_item.command == CMD_NONE && verdict_item.received_crc == 16'd0 &&
       verdict_item.computed_crc == 16'd0))
  // A named command comes with a header-based status, and only then.
  `CFC_ASSERT(a_cmd_status, clk, rst,
    verdict_valid |-> ((verdict_item.command == CMD_NONE) ==
      (verdict_item.status == ST_TOO_SHORT || verdict_item.status == ST_UNKNOWN)))

endmodule

`default_nettype wire
